@@ rtl/hred_pkg.sv @@
// hred_pkg: shared types, codes and character tables for the http request end detector
// no dependencies; used by hred_core and http_request_end_detector_top
`default_nettype none

package hred_pkg;

  // width of the content length value and body byte count
  localparam int LENGTH_BITS = 32;
  localparam int KEY_LEN     = 15;

  typedef logic [LENGTH_BITS-1:0] len_t;
  typedef logic [LENGTH_BITS+3:0] len_wide_t;

  localparam len_t LEN_MAX = {LENGTH_BITS{1'b1}};

  // item opcodes
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // completion kinds
  localparam logic [1:0] END_NONE   = 2'd0;
  localparam logic [1:0] END_METHOD = 2'd1;
  localparam logic [1:0] END_LENGTH = 2'd2;
  localparam logic [1:0] END_CHUNK  = 2'd3;

  // characters
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // content length parser phase
  typedef enum logic [3:0] {
    LP_KEY    = 4'b0001,
    LP_SPACE  = 4'b0010,
    LP_DIGITS = 4'b0100,
    LP_FINAL  = 4'b1000
  } len_phase_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic       done_res;
    logic       header_done;
    logic [1:0] end_kind;
  } res_t;

  // "Content-Length:"
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h4C; // L
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      4'd14:   c = 8'h3A; // :
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "GET "
  function automatic logic [7:0] get_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h47;
      2'd1:    c = 8'h45;
      2'd2:    c = 8'h54;
      default: c = 8'h20;
    endcase
    return c;
  endfunction

  // "DELETE "
  function automatic logic [7:0] del_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h44;
      3'd1:    c = 8'h45;
      3'd2:    c = 8'h4C;
      3'd3:    c = 8'h45;
      3'd4:    c = 8'h54;
      3'd5:    c = 8'h45;
      3'd6:    c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "0" CR LF
  function automatic logic [7:0] zero_crlf_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = CH_ZERO;
      2'd1:    c = CH_CR;
      default: c = CH_LF;
    endcase
    return c;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0B) ||
           (b == 8'h0C) || (b == 8'h0D);
  endfunction

endpackage

`default_nettype wire

@@ rtl/hred_core.sv @@
// hred_core: request state registers and the per-byte update of all matchers and counters
// depends on hred_pkg
`default_nettype none

module hred_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire hred_pkg::req_t item,
  output hred_pkg::res_t     result
);

  // state registers
  logic [1:0]           crlf_progress, crlf_progress_next;
  logic                 header_seen, header_seen_next;
  logic [2:0]           method_match, method_match_next;
  logic [1:0]           method_alive, method_alive_next;
  logic [3:0]           length_key_progress, length_key_progress_next;
  hred_pkg::len_phase_t length_phase, length_phase_next;
  hred_pkg::len_t       length_value, length_value_next;
  hred_pkg::len_t       body_count, body_count_next;
  logic [1:0]           zero_crlf_progress, zero_crlf_progress_next;
  logic                 chunk_end_armed, chunk_end_armed_next;
  logic                 done_flag, done_flag_next;
  logic [1:0]           done_kind, done_kind_next;

  logic [7:0]          b;
  logic                is_digit;
  logic [3:0]          digit;
  hred_pkg::len_wide_t scaled;
  logic                crlf_hit;
  logic [1:0]          crlf_after;
  logic                chunk_done;
  logic                get_ok;
  logic                del_ok;

  assign b        = item.data_byte;
  assign is_digit = (b >= hred_pkg::CH_ZERO) && (b <= hred_pkg::CH_NINE);
  assign digit    = b[3:0];

  // value * 10 + digit, wide enough to spot overflow
  assign scaled = ({4'd0, length_value} << 3) + ({4'd0, length_value} << 1) +
                  {{hred_pkg::LENGTH_BITS{1'b0}}, digit};

  // cr lf cr lf matcher step on the current progress
  always_comb begin
    logic [7:0] want;
    want       = crlf_progress[0] ? hred_pkg::CH_LF : hred_pkg::CH_CR;
    crlf_hit   = 1'b0;
    crlf_after = 2'd0;
    if (b == want) begin
      if (crlf_progress == 2'd3) begin
        crlf_hit   = 1'b1;
        crlf_after = 2'd0;
      end else begin
        crlf_after = crlf_progress + 2'd1;
      end
    end else begin
      crlf_after = (b == hred_pkg::CH_CR) ? 2'd1 : 2'd0;
    end
  end

  // next state for one transaction
  always_comb begin
    crlf_progress_next       = crlf_progress;
    header_seen_next         = header_seen;
    method_match_next        = method_match;
    method_alive_next        = method_alive;
    length_key_progress_next = length_key_progress;
    length_phase_next        = length_phase;
    length_value_next        = length_value;
    body_count_next          = body_count;
    zero_crlf_progress_next  = zero_crlf_progress;
    chunk_end_armed_next     = chunk_end_armed;
    done_flag_next           = done_flag;
    done_kind_next           = done_kind;
    chunk_done               = 1'b0;
    get_ok                   = 1'b0;
    del_ok                   = 1'b0;

    if (item.op == hred_pkg::OP_CLEAR) begin
      crlf_progress_next       = 2'd0;
      header_seen_next         = 1'b0;
      method_match_next        = 3'd0;
      method_alive_next        = 2'b11;
      length_key_progress_next = 4'd0;
      length_phase_next        = hred_pkg::LP_KEY;
      length_value_next        = '0;
      body_count_next          = '0;
      zero_crlf_progress_next  = 2'd0;
      chunk_end_armed_next     = 1'b0;
      done_flag_next           = 1'b0;
      done_kind_next           = hred_pkg::END_NONE;
    end else begin
      // method prefix
      if (method_match != 3'd7) begin
        if (!method_match[2] && (b != hred_pkg::get_char(method_match[1:0]))) begin
          method_alive_next[0] = 1'b0;
        end
        if (b != hred_pkg::del_char(method_match)) begin
          method_alive_next[1] = 1'b0;
        end
        method_match_next = method_match + 3'd1;
      end

      if (!header_seen) begin
        // content length key and value
        unique case (length_phase)
          hred_pkg::LP_KEY: begin
            if (b == hred_pkg::key_char(length_key_progress)) begin
              length_key_progress_next = length_key_progress + 4'd1;
              if (length_key_progress == 4'(hred_pkg::KEY_LEN - 1)) begin
                length_phase_next = hred_pkg::LP_SPACE;
              end
            end else begin
              length_key_progress_next = (b == hred_pkg::key_char(4'd0)) ? 4'd1 : 4'd0;
            end
          end
          hred_pkg::LP_SPACE: begin
            if (is_digit) begin
              length_value_next = {{(hred_pkg::LENGTH_BITS-4){1'b0}}, digit};
              length_phase_next = hred_pkg::LP_DIGITS;
            end else if (!hred_pkg::is_space(b)) begin
              length_phase_next = hred_pkg::LP_FINAL;
            end
          end
          hred_pkg::LP_DIGITS: begin
            if (is_digit) begin
              if (scaled[hred_pkg::LENGTH_BITS+3:hred_pkg::LENGTH_BITS] != 4'd0) begin
                length_value_next = hred_pkg::LEN_MAX;
              end else begin
                length_value_next = scaled[hred_pkg::LENGTH_BITS-1:0];
              end
            end else begin
              length_phase_next = hred_pkg::LP_FINAL;
            end
          end
          default: begin
          end
        endcase
        // blank line ends the header
        crlf_progress_next = crlf_after;
        if (crlf_hit) begin
          header_seen_next = 1'b1;
          if ((length_phase_next == hred_pkg::LP_SPACE) ||
              (length_phase_next == hred_pkg::LP_DIGITS)) begin
            length_phase_next = hred_pkg::LP_FINAL;
          end
        end
      end else begin
        // body byte count
        if (body_count != hred_pkg::LEN_MAX) begin
          body_count_next = body_count + 1'b1;
        end
        // chunk terminator
        if (!chunk_end_armed) begin
          if (b == hred_pkg::zero_crlf_char(zero_crlf_progress)) begin
            if (zero_crlf_progress == 2'd2) begin
              zero_crlf_progress_next = 2'd0;
              chunk_end_armed_next    = 1'b1;
              crlf_progress_next      = 2'd2;
            end else begin
              zero_crlf_progress_next = zero_crlf_progress + 2'd1;
            end
          end else begin
            zero_crlf_progress_next = (b == hred_pkg::CH_ZERO) ? 2'd1 : 2'd0;
          end
        end else begin
          crlf_progress_next = crlf_after;
          chunk_done         = crlf_hit;
        end
      end

      // verdict, sticky until clear
      get_ok = method_alive_next[0] && (method_match_next >= 3'd4);
      del_ok = method_alive_next[1] && (method_match_next == 3'd7);
      if (header_seen_next && !done_flag) begin
        priority if (get_ok || del_ok) begin
          done_flag_next = 1'b1;
          done_kind_next = hred_pkg::END_METHOD;
        end else if (length_phase_next != hred_pkg::LP_KEY) begin
          if (body_count_next >= length_value_next) begin
            done_flag_next = 1'b1;
            done_kind_next = hred_pkg::END_LENGTH;
          end
        end else if (chunk_done) begin
          done_flag_next = 1'b1;
          done_kind_next = hred_pkg::END_CHUNK;
        end
      end
    end
  end

  assign result.done_res    = done_flag_next;
  assign result.header_done = header_seen_next;
  assign result.end_kind    = done_kind_next;

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      crlf_progress       <= 2'd0;
      header_seen         <= 1'b0;
      method_match        <= 3'd0;
      method_alive        <= 2'b11;
      length_key_progress <= 4'd0;
      length_phase        <= hred_pkg::LP_KEY;
      length_value        <= '0;
      body_count          <= '0;
      zero_crlf_progress  <= 2'd0;
      chunk_end_armed     <= 1'b0;
      done_flag           <= 1'b0;
      done_kind           <= hred_pkg::END_NONE;
    end else if (step) begin
      crlf_progress       <= crlf_progress_next;
      header_seen         <= header_seen_next;
      method_match        <= method_match_next;
      method_alive        <= method_alive_next;
      length_key_progress <= length_key_progress_next;
      length_phase        <= length_phase_next;
      length_value        <= length_value_next;
      body_count          <= body_count_next;
      zero_crlf_progress  <= zero_crlf_progress_next;
      chunk_end_armed     <= chunk_end_armed_next;
      done_flag           <= done_flag_next;
      done_kind           <= done_kind_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/http_request_end_detector_top.sv @@
// http_request_end_detector_top: input register, result register and handshake
// an accepted transaction waits in the input register; its result is then offered from the result register
// throughput: one transaction per cycle if res_ready is high; hred_core updates once per item
// the result register lets a new transaction in while a finished result waits
// reset (rst, synchronous, active high) empties both registers and clears the request state
// depends on hred_pkg and hred_core
`default_nettype none

module http_request_end_detector_top (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire hred_pkg::req_t req,
  output logic                res_valid,
  input  wire logic           res_ready,
  output hred_pkg::res_t      res
);

  logic           in_full;
  hred_pkg::req_t in_item;
  logic           advance;
  hred_pkg::res_t core_result;

  // the held transaction moves on when the result register is free or being emptied
  assign advance   = in_full && (!res_valid || res_ready);
  assign req_ready = !in_full || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (req_ready) begin
      in_full <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      in_item <= req;
    end
  end

  hred_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_item),
    .result (core_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= core_result;
    end
  end

endmodule

`default_nettype wire
